FILE: rtl/vpmc_pkg.sv
// Package: types and constants shared by the vehicle power mode controller.
package vpmc_pkg;

    localparam int unsigned ModeW    = 3;
    localparam int unsigned TimeoutW = 22;
    localparam int unsigned PassCntW = 4;

    localparam logic [ModeW-1:0] MODE_UNKNOWN = 3'd0;
    localparam logic [ModeW-1:0] MODE_LOST    = 3'd1;
    localparam logic [ModeW-1:0] MODE_BACKUP  = 3'd2;
    localparam logic [ModeW-1:0] MODE_NORMAL  = 3'd3;
    localparam logic [ModeW-1:0] MODE_STANDBY = 3'd4;
    localparam logic [ModeW-1:0] MODE_READY   = 3'd5;
    localparam logic [ModeW-1:0] MODE_RUN     = 3'd6;

    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 22'd60000;
    localparam logic [PassCntW-1:0] PASS_LAST     = 4'd15;

    typedef struct packed {
        logic             override_valid;
        logic [ModeW-1:0] override_mode;
        logic [31:0]      now_ms;
        logic             power_ok;
        logic             start_pressed;
        logic             shutdown_pressed;
        logic             remote_nearby;
        logic             finger_matched;
        logic             node_error;
        logic             motor_running;
    } vpmc_in_t;

    typedef struct packed {
        logic [ModeW-1:0] vehicle_mode;
        logic             report_yield;
        logic             stop_tasks;
        logic             start_tasks;
        logic             save_deferred;
        logic             remote_reset;
        logic             clear_finger;
    } vpmc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } vpmc_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } vpmc_cmd_t;

    typedef struct packed {
        logic settled;
    } vpmc_sts_t;

endpackage

FILE: rtl/vpmc_datapath.sv
// Datapath: mode state, latched check inputs, one rule pass per step, result flags.
module vpmc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vpmc_pkg::vpmc_cmd_t             cmd,
    output vpmc_pkg::vpmc_sts_t             sts,
    input  vpmc_pkg::vpmc_in_t              in_item,
    output vpmc_pkg::vpmc_out_t             out_item,
    input  logic                            cfg_we,
    input  logic [vpmc_pkg::TimeoutW-1:0]   cfg_data
);
    import vpmc_pkg::*;

    logic [TimeoutW-1:0] timeout_reg;
    logic [ModeW-1:0]    mode_reg, mode_next;
    logic [ModeW-1:0]    last_reg, last_next;
    logic [31:0]         entry_reg, entry_next;
    vpmc_in_t            item_reg;
    logic                start_reg, start_next;
    logic                shut_reg, shut_next;
    logic                finger_reg, finger_next;
    logic                y_reg, y_next;
    logic                stp_reg, stp_next;
    logic                sta_reg, sta_next;
    logic                sav_reg, sav_next;
    logic                rr_reg, rr_next;
    logic                cf_reg, cf_next;

    // one pass of the transition rules
    always_comb
    begin
        logic        entering;
        logic        s_eff;
        logic        sd_eff;
        logic        f_eff;
        logic [31:0] elapsed;
        logic        pwr;

        mode_next   = mode_reg;
        last_next   = last_reg;
        entry_next  = entry_reg;
        start_next  = start_reg;
        shut_next   = shut_reg;
        finger_next = finger_reg;
        y_next      = y_reg;
        stp_next    = stp_reg;
        sta_next    = sta_reg;
        sav_next    = sav_reg;
        rr_next     = rr_reg;
        cf_next     = cf_reg;

        pwr      = item_reg.power_ok;
        entering = (last_reg != mode_reg);
        s_eff    = start_reg & ~entering;
        sd_eff   = shut_reg;
        f_eff    = finger_reg;
        elapsed  = entering ? 32'd0 : (item_reg.now_ms - entry_reg);

        case (mode_reg)
            MODE_LOST:
            begin
                if (entering)
                begin
                    last_next = MODE_LOST;
                    y_next    = 1'b1;
                end
                if (pwr)
                    mode_next = MODE_NORMAL;
            end
            MODE_BACKUP:
            begin
                if (entering)
                begin
                    last_next  = MODE_BACKUP;
                    y_next     = 1'b1;
                    stp_next   = 1'b1;
                    entry_next = item_reg.now_ms;
                end
                if (elapsed > {{(32-TimeoutW){1'b0}}, timeout_reg})
                    mode_next = MODE_LOST;
                else if (pwr)
                    mode_next = MODE_NORMAL;
            end
            MODE_NORMAL:
            begin
                if (entering)
                begin
                    if (last_reg > MODE_NORMAL)
                        sav_next = 1'b1;
                    last_next  = MODE_NORMAL;
                    y_next     = 1'b1;
                    sta_next   = 1'b1;
                    start_next = 1'b0;
                    shut_next  = 1'b0;
                end
                if (!pwr)
                    mode_next = MODE_BACKUP;
                else if (s_eff)
                begin
                    if (item_reg.remote_nearby)
                        mode_next = MODE_STANDBY;
                    else
                        rr_next = 1'b1;
                end
            end
            MODE_STANDBY:
            begin
                if (entering)
                begin
                    last_next   = MODE_STANDBY;
                    start_next  = 1'b0;
                    cf_next     = 1'b1;
                    finger_next = 1'b0;
                    f_eff       = 1'b0;
                end
                if (!pwr || sd_eff)
                    mode_next = MODE_NORMAL;
                else if (f_eff)
                    mode_next = MODE_READY;
            end
            MODE_READY:
            begin
                if (entering)
                begin
                    last_next  = MODE_READY;
                    start_next = 1'b0;
                end
                if (!pwr || sd_eff)
                    mode_next = MODE_STANDBY;
                else if (!item_reg.node_error && s_eff)
                    mode_next = MODE_RUN;
            end
            MODE_RUN:
            begin
                if (entering)
                begin
                    last_next  = MODE_RUN;
                    start_next = 1'b0;
                end
                if (!pwr || (s_eff && !item_reg.motor_running) || sd_eff
                    || item_reg.node_error)
                    mode_next = MODE_READY;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.settled = (mode_next == mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            mode_reg    <= MODE_UNKNOWN;
            last_reg    <= MODE_UNKNOWN;
            entry_reg   <= '0;
            y_reg       <= 1'b0;
            stp_reg     <= 1'b0;
            sta_reg     <= 1'b0;
            sav_reg     <= 1'b0;
            rr_reg      <= 1'b0;
            cf_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_data;
            if (cmd.load)
            begin
                if (in_item.override_valid)
                    mode_reg <= in_item.override_mode;
                y_reg   <= 1'b0;
                stp_reg <= 1'b0;
                sta_reg <= 1'b0;
                sav_reg <= 1'b0;
                rr_reg  <= 1'b0;
                cf_reg  <= 1'b0;
            end
            else if (cmd.step)
            begin
                mode_reg  <= mode_next;
                last_reg  <= last_next;
                entry_reg <= entry_next;
                y_reg     <= y_next;
                stp_reg   <= stp_next;
                sta_reg   <= sta_next;
                sav_reg   <= sav_next;
                rr_reg    <= rr_next;
                cf_reg    <= cf_next;
            end
        end
    end

    // latched item and working copies of start, shutdown and finger
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= in_item;
            start_reg  <= in_item.start_pressed;
            shut_reg   <= in_item.shutdown_pressed;
            finger_reg <= in_item.finger_matched;
        end
        else if (cmd.step)
        begin
            start_reg  <= start_next;
            shut_reg   <= shut_next;
            finger_reg <= finger_next;
        end
    end

    assign out_item.vehicle_mode  = mode_reg;
    assign out_item.report_yield  = y_reg;
    assign out_item.stop_tasks    = stp_reg;
    assign out_item.start_tasks   = sta_reg;
    assign out_item.save_deferred = sav_reg;
    assign out_item.remote_reset  = rr_reg;
    assign out_item.clear_finger  = cf_reg;

    a_stop_yields: assert property (@(posedge clk) disable iff (!rst_n)
        stp_reg |-> y_reg)
        else $error("stop_tasks without report_yield");
    a_start_yields: assert property (@(posedge clk) disable iff (!rst_n)
        sta_reg |-> y_reg)
        else $error("start_tasks without report_yield");
    a_save_start: assert property (@(posedge clk) disable iff (!rst_n)
        sav_reg |-> sta_reg)
        else $error("save_deferred without start_tasks");

endmodule

FILE: rtl/vpmc_ctrl.sv
// Controller: sequences load, rule passes and result delivery for one item.
module vpmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vpmc_pkg::vpmc_cmd_t  cmd,
    input  vpmc_pkg::vpmc_sts_t  sts
);
    import vpmc_pkg::*;

    vpmc_state_t         state_reg, state_next;
    logic [PassCntW-1:0] pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                cmd.step = 1'b1;
                if (sts.settled || pass_reg == PASS_LAST)
                    state_next = ST_DONE;
                else
                    pass_next = pass_reg + 1'b1;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_BUSY))
        else $error("accepted item did not start passes");
    a_settle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && sts.settled) |=> (state_reg == ST_DONE))
        else $error("settled mode not reported");
    a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result withdrawn before taken");

endmodule

FILE: rtl/vehicle_power_mode_controller_top.sv
// Top level of the vehicle power mode controller.
//
//  channel | signals                      | moves
//  in      | in_valid/in_ready/in_data    | one check item
//  out     | out_valid/out_ready/out_data | one result item per check
//  cfg     | cfg_valid/cfg_ready/cfg_data | backup timeout in ms
//
// An item is loaded, then runs rule passes (at most 16, fewer once the mode
// settles) in the shared pass logic, then waits for the result handshake.
// One item is in flight at a time; in_ready is low until the result is taken.
// Reset: mode and last entered mode unknown, backup entry time 0, timeout 60000.
// cfg_ready is always high.
module vehicle_power_mode_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  vpmc_pkg::vpmc_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output vpmc_pkg::vpmc_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vpmc_pkg::TimeoutW-1:0]  cfg_data
);
    import vpmc_pkg::*;

    vpmc_cmd_t cmd;
    vpmc_sts_t sts;

    assign cfg_ready = 1'b1;

    vpmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vpmc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_item  (in_data),
        .out_item (out_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data)
    );

endmodule
